>>> rtl/indexed_insert_remove_list_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed insert/remove list
// Both macros expect signals named clk and rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IIRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iirl: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IIRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iirl: next-cycle check failed");

`endif

>>> rtl/iirl_pkg.sv
// ---------------------------------------------------------------------------
// iirl_pkg
// Shared sizes, command and status codes and cell control type for the list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iirl_pkg;

  localparam int DEPTH    = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 7;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int GRP      = 8;
  localparam int NGRP     = (DEPTH + GRP - 1) / GRP;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LEFT  = 2'd1;
  localparam logic [1:0] CELL_RIGHT = 2'd2;
  localparam logic [1:0] CELL_NEW   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       rd_sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/iirl_cell.sv
// ---------------------------------------------------------------------------
// iirl_cell
// One list slot: holds, shifts in from either neighbour or loads a new word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iirl_cell (
  input  wire                            clk,
  input  iirl_pkg::cell_ctrl_t           ctrl,
  input  wire [iirl_pkg::DATA_W-1:0]     left_data,
  input  wire [iirl_pkg::DATA_W-1:0]     right_data,
  input  wire [iirl_pkg::DATA_W-1:0]     new_data,
  output logic [iirl_pkg::DATA_W-1:0]    data_q,
  output logic [iirl_pkg::DATA_W-1:0]    rd_data
);

  logic [iirl_pkg::DATA_W-1:0] data_r;
  logic [iirl_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctrl.op)
      iirl_pkg::CELL_LEFT:  data_nxt = left_data;
      iirl_pkg::CELL_RIGHT: data_nxt = right_data;
      iirl_pkg::CELL_NEW:   data_nxt = new_data;
      default:              data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q  = data_r;
  // The read port is an AND-OR term, so only the addressed cell contributes.
  assign rd_data = ctrl.rd_sel ? data_r : '0;

endmodule

`default_nettype wire

>>> rtl/indexed_insert_remove_list_top.sv
// ---------------------------------------------------------------------------
// indexed_insert_remove_list_top
// Ordered list of up to DEPTH words with get, set, insert and remove by index.
// ---------------------------------------------------------------------------
// Each input transaction carries one command and yields exactly one result
// transaction. The list lives in a row of cells; an insert or remove shifts
// every later cell by one position in the cycle the command is accepted. The
// word read by get or remove is gathered through a two-level registered OR
// tree over the cells: the group ORs are registered on acceptance and the
// final OR is registered in S_GATHER, after which out_tvalid rises in S_OUT.
// The block takes one command at a time: the next command is accepted in the
// cycle after the result transaction completes. No clearing pass is needed
// after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_insert_remove_list_top_defines.svh"

module indexed_insert_remove_list_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  // in_tdata from bit 0: command[1:0], position[8:2], entry_value[40:9], zero pad
  input  wire [iirl_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // out_tdata from bit 0: status[1:0], entry_out[33:2], count_after[40:34], zero pad
  output logic [iirl_pkg::OUT_W-1:0]  out_tdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GATHER = 2'd1;
  localparam logic [1:0] S_OUT    = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  logic [iirl_pkg::CNT_W-1:0]  count_r;
  logic [iirl_pkg::STAT_W-1:0] stat_r;
  logic [iirl_pkg::DATA_W-1:0] grp_r [iirl_pkg::NGRP];
  logic [iirl_pkg::STAT_W-1:0] out_status_r;
  logic [iirl_pkg::DATA_W-1:0] out_entry_r;
  logic [iirl_pkg::OCNT_W-1:0] out_count_r;

  logic [iirl_pkg::CMD_W-1:0]  cmd;
  logic [iirl_pkg::POS_W-1:0]  pos;
  logic [iirl_pkg::DATA_W-1:0] val;
  logic                        acc;
  logic                        in_range;
  logic                        ins_ok;
  logic                        ins_done;
  logic [31:0]                 pos_ext;
  logic [31:0]                 cnt_ext;
  logic [iirl_pkg::STAT_W-1:0] stat_nxt;
  logic [iirl_pkg::DATA_W-1:0] grp_nxt [iirl_pkg::NGRP];
  logic [iirl_pkg::DATA_W-1:0] gather;

  logic [iirl_pkg::DATA_W-1:0] cell_q [iirl_pkg::DEPTH];
  logic [iirl_pkg::DATA_W-1:0] cell_rd [iirl_pkg::DEPTH];

  assign cmd = in_tdata[1:0];
  assign pos = in_tdata[8:2];
  assign val = in_tdata[40:9];

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid & in_tready;

  assign pos_ext  = 32'(pos);
  assign cnt_ext  = 32'(count_r);
  assign in_range = pos_ext < cnt_ext;
  assign ins_ok   = (pos_ext <= cnt_ext) && (cnt_ext != iirl_pkg::DEPTH);
  assign ins_done = acc && (cmd == iirl_pkg::CMD_INSERT) && ins_ok;

  always_comb begin
    stat_nxt = iirl_pkg::ST_OK;
    if (cmd == iirl_pkg::CMD_INSERT) begin
      if (pos_ext > cnt_ext) begin
        stat_nxt = iirl_pkg::ST_RANGE;
      end else if (cnt_ext == iirl_pkg::DEPTH) begin
        stat_nxt = iirl_pkg::ST_FULL;
      end
    end else if (!in_range) begin
      stat_nxt = iirl_pkg::ST_RANGE;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < iirl_pkg::DEPTH; gi++) begin : g_cell
      iirl_pkg::cell_ctrl_t        cell_ctrl;
      logic [iirl_pkg::DATA_W-1:0] left_d;
      logic [iirl_pkg::DATA_W-1:0] right_d;

      always_comb begin
        cell_ctrl.op     = iirl_pkg::CELL_HOLD;
        cell_ctrl.rd_sel = (pos_ext == gi);
        if (acc) begin
          case (cmd)
            iirl_pkg::CMD_SET: begin
              if (in_range && pos_ext == gi) cell_ctrl.op = iirl_pkg::CELL_NEW;
            end
            iirl_pkg::CMD_INSERT: begin
              if (ins_ok) begin
                if (pos_ext == gi) begin
                  cell_ctrl.op = iirl_pkg::CELL_NEW;
                end else if (gi > pos_ext) begin
                  cell_ctrl.op = iirl_pkg::CELL_LEFT;
                end
              end
            end
            iirl_pkg::CMD_REMOVE: begin
              if (in_range && gi >= pos_ext) cell_ctrl.op = iirl_pkg::CELL_RIGHT;
            end
            default: ;
          endcase
        end
      end

      if (gi == 0) begin : g_first
        assign left_d = val;
      end else begin : g_mid_l
        assign left_d = cell_q[gi-1];
      end
      // The last cell shifts in its own word; it lies beyond the count then.
      if (gi == iirl_pkg::DEPTH - 1) begin : g_last
        assign right_d = cell_q[gi];
      end else begin : g_mid_r
        assign right_d = cell_q[gi+1];
      end

      iirl_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .left_data  (left_d),
        .right_data (right_d),
        .new_data   (val),
        .data_q     (cell_q[gi]),
        .rd_data    (cell_rd[gi])
      );
    end
  endgenerate

  // First level of the read tree: OR the cells in groups, from pre-update data.
  always_comb begin
    for (int g = 0; g < iirl_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < iirl_pkg::GRP; j++) begin
        if (g * iirl_pkg::GRP + j < iirl_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * iirl_pkg::GRP + j];
        end
      end
    end
  end

  always_comb begin
    gather = '0;
    for (int g = 0; g < iirl_pkg::NGRP; g++) begin
      gather = gather | grp_r[g];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (acc) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_OUT;
      S_OUT:    if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ins_done) begin
        count_r <= count_r + iirl_pkg::CNT_W'(1);
      end else if (acc && cmd == iirl_pkg::CMD_REMOVE && in_range) begin
        count_r <= count_r - iirl_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stat_r <= stat_nxt;
      for (int g = 0; g < iirl_pkg::NGRP; g++) begin
        // Only a successful get or remove returns a word.
        if ((cmd == iirl_pkg::CMD_GET || cmd == iirl_pkg::CMD_REMOVE) && in_range) begin
          grp_r[g] <= grp_nxt[g];
        end else begin
          grp_r[g] <= '0;
        end
      end
    end
    if (state_r == S_GATHER) begin
      out_status_r <= stat_r;
      out_entry_r  <= gather;
      out_count_r  <= iirl_pkg::OCNT_W'(count_r);
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, out_count_r, out_entry_r, out_status_r};

  `IIRL_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_r) <= iirl_pkg::DEPTH)
  `IIRL_ASSERT_NXT(a_insert_count, ins_done, count_r == $past(count_r) + iirl_pkg::CNT_W'(1))
  `IIRL_ASSERT_IMP(a_one_at_a_time, out_tvalid, !in_tready)
  `IIRL_ASSERT_IMP(a_error_zero, out_tvalid && out_status_r != iirl_pkg::ST_OK, out_entry_r == '0)

endmodule

`default_nettype wire
